// ===== hdl/vprc_pkg.sv =====
// Shared constants, types and helper functions for the validity period codec.
`timescale 1ns / 1ps
`default_nettype none

package vprc_pkg;

    // Duration constants in seconds
    localparam logic [31:0] DUR_5MIN   = 32'd300;
    localparam logic [31:0] DUR_30MIN  = 32'd1800;
    localparam logic [31:0] DUR_12HR   = 32'd43200;
    localparam logic [31:0] DUR_1DAY   = 32'd86400;
    localparam logic [31:0] DUR_1WEEK  = 32'd604800;
    localparam logic [31:0] DUR_2DAY   = 32'd172800;
    localparam logic [31:0] DUR_30DAY  = 32'd2592000;
    localparam logic [31:0] DUR_5WEEK  = 32'd3024000;
    localparam logic [31:0] DUR_63WEEK = 32'd38102400;

    // Code landmarks
    localparam logic [7:0] CODE_HALF_DAY  = 8'd143;
    localparam logic [7:0] CODE_DAY       = 8'd167;
    localparam logic [7:0] CODE_MONTH     = 8'd196;
    localparam logic [7:0] CODE_DAY_BASE  = 8'd166;
    localparam logic [7:0] CODE_WEEK_BASE = 8'd192;
    localparam logic [7:0] CODE_MAX       = 8'd255;

    // Operation codes
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // Widths
    localparam int NUM_W  = 26;   // numerator / seconds width
    localparam int DIV_W  = 20;   // largest step (one week) fits here
    localparam int RCP_W  = 32;   // reciprocal scale 2^32
    localparam int QUO_W  = 8;

    // floor(2^32 / step); quotient estimate is exact or one low
    localparam logic [63:0] SCALE       = 64'd1 << RCP_W;
    localparam logic [31:0] RCP_MIN5    = 32'(SCALE / 64'd300);
    localparam logic [31:0] RCP_HALF_HR = 32'(SCALE / 64'd1800);
    localparam logic [31:0] RCP_DAY     = 32'(SCALE / 64'd86400);
    localparam logic [31:0] RCP_WEEK    = 32'(SCALE / 64'd604800);

    typedef enum logic [1:0] {
        BAND_MIN5    = 2'd0,
        BAND_HALF_HR = 2'd1,
        BAND_DAY     = 2'd2,
        BAND_WEEK    = 2'd3
    } band_t;

    // Classified item leaving the front stage
    typedef struct packed {
        logic             op;
        logic             sat;
        band_t            band;
        logic [NUM_W-1:0] num;   // encode numerator
        logic [7:0]       mult;  // decode step count
    } cls_t;

    function automatic logic [DIV_W-1:0] band_div(input band_t band);
        logic [DIV_W-1:0] d;
        case (band)
            BAND_MIN5:    d = DIV_W'(DUR_5MIN);
            BAND_HALF_HR: d = DIV_W'(DUR_30MIN);
            BAND_DAY:     d = DIV_W'(DUR_1DAY);
            BAND_WEEK:    d = DIV_W'(DUR_1WEEK);
            default:      d = DIV_W'(DUR_5MIN);
        endcase
        return d;
    endfunction

    function automatic logic [RCP_W-1:0] band_recip(input band_t band);
        logic [RCP_W-1:0] r;
        case (band)
            BAND_MIN5:    r = RCP_MIN5;
            BAND_HALF_HR: r = RCP_HALF_HR;
            BAND_DAY:     r = RCP_DAY;
            BAND_WEEK:    r = RCP_WEEK;
            default:      r = RCP_MIN5;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/vprc_classify.sv =====
// Front stage logic: band selection, clamping and step count for both directions.
`timescale 1ns / 1ps
`default_nettype none

module vprc_classify (
    input  wire logic        operation,
    input  wire logic [31:0] duration_seconds,
    input  wire logic [7:0]  period_code,
    output vprc_pkg::cls_t   cls
);
    import vprc_pkg::*;

    always_comb
    begin
        cls      = '0;
        cls.op   = operation;
        cls.band = BAND_MIN5;
        if (operation == OP_ENCODE)
        begin
            if (duration_seconds <= DUR_12HR)
            begin
                cls.band = BAND_MIN5;
                cls.num  = (duration_seconds < DUR_5MIN) ? NUM_W'(DUR_5MIN)
                                                         : duration_seconds[NUM_W-1:0];
            end
            else if (duration_seconds <= DUR_1DAY)
            begin
                cls.band = BAND_HALF_HR;
                cls.num  = NUM_W'(duration_seconds - DUR_12HR);
            end
            else if (duration_seconds <= DUR_30DAY)
            begin
                cls.band = BAND_DAY;
                cls.num  = (duration_seconds < DUR_2DAY) ? NUM_W'(DUR_2DAY)
                                                         : duration_seconds[NUM_W-1:0];
            end
            else if (duration_seconds <= DUR_63WEEK)
            begin
                cls.band = BAND_WEEK;
                cls.num  = (duration_seconds < DUR_5WEEK) ? NUM_W'(DUR_5WEEK)
                                                          : duration_seconds[NUM_W-1:0];
            end
            else
            begin
                cls.band = BAND_WEEK;
                cls.sat  = 1'b1;
                cls.num  = NUM_W'(DUR_5WEEK);
            end
        end
        else
        begin
            if (period_code <= CODE_HALF_DAY)
            begin
                cls.band = BAND_MIN5;
                cls.mult = period_code + 8'd1;
            end
            else if (period_code <= CODE_DAY)
            begin
                cls.band = BAND_HALF_HR;
                cls.mult = period_code - CODE_HALF_DAY;
            end
            else if (period_code <= CODE_MONTH)
            begin
                cls.band = BAND_DAY;
                cls.mult = period_code - CODE_DAY_BASE;
            end
            else
            begin
                cls.band = BAND_WEEK;
                cls.mult = period_code - CODE_WEEK_BASE;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/validity_period_relative_codec.sv =====
// Top level: four-stage pipelined relative validity period encoder/decoder.
// The input transfer loads the classify register; reciprocal multiply, step
//   multiply and correct/offset then load the stage 2, stage 3 and output
//   registers in turn. Throughput: one item per cycle unless an untaken result
//   stalls the output; the step multiplier is shared by both directions.
// Reset: rst_n asynchronously clears all stage valid bits; payload is not reset.
`timescale 1ns / 1ps
`default_nettype none

module validity_period_relative_codec (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic        operation,
    input  wire logic [31:0] duration_seconds,
    input  wire logic [7:0]  period_code,
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic [7:0]  code_out,
    output      logic [25:0] seconds_out,
    output      logic        saturated
);
    import vprc_pkg::*;

    // Whole pipe moves together; it halts only when the output holds an
    // untaken result, so nothing is dropped or repeated under a stall.
    logic adv;
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // ---------------- stage 1: classify ----------------
    cls_t cls_next;
    cls_t s1_reg;
    logic s1_vld_reg;

    vprc_classify u_classify (
        .operation        (operation),
        .duration_seconds (duration_seconds),
        .period_code      (period_code),
        .cls              (cls_next)
    );

    // ---------------- stage 2: quotient estimate ----------------
    // q0 = floor(num * floor(2^32/D) / 2^32) is q or q-1
    logic [NUM_W+RCP_W-1:0] rcp_prod;
    logic [QUO_W-1:0]       q0_next;
    cls_t                   s2_reg;
    logic [QUO_W-1:0]       q0_reg;
    logic                   s2_vld_reg;

    assign rcp_prod = (NUM_W+RCP_W)'(s1_reg.num) * (NUM_W+RCP_W)'(band_recip(s1_reg.band));
    assign q0_next  = rcp_prod[RCP_W+QUO_W-1:RCP_W];

    // ---------------- stage 3: step multiply ----------------
    // Encode: q0*D for the remainder check. Decode: steps*D is the answer.
    logic [7:0]             mul_a;
    logic [DIV_W+7:0]       step_prod;
    cls_t                   s3_reg;
    logic [QUO_W-1:0]       q0_s3_reg;
    logic [NUM_W-1:0]       prod_reg;
    logic                   s3_vld_reg;

    assign mul_a     = (s2_reg.op == OP_DECODE) ? s2_reg.mult : q0_reg;
    assign step_prod = (DIV_W+8)'(mul_a) * (DIV_W+8)'(band_div(s2_reg.band));

    // ---------------- stage 4: correct and map to result ----------------
    logic [NUM_W:0]    rem;
    logic [QUO_W-1:0]  quo;
    logic [7:0]        code_next;
    logic [NUM_W-1:0]  secs_next;

    always_comb
    begin
        rem = {1'b0, s3_reg.num} - {1'b0, prod_reg};
        quo = (rem >= (NUM_W+1)'(band_div(s3_reg.band))) ? q0_s3_reg + 8'd1 : q0_s3_reg;
        case (s3_reg.band)
            BAND_MIN5:    code_next = quo - 8'd1;
            BAND_HALF_HR: code_next = quo + CODE_HALF_DAY;
            BAND_DAY:     code_next = quo + CODE_DAY_BASE;
            BAND_WEEK:    code_next = quo + CODE_WEEK_BASE;
            default:      code_next = quo;
        endcase
        if (s3_reg.sat)
        begin
            code_next = CODE_MAX;
        end
        // half-hour band counts from twelve hours
        secs_next = (s3_reg.band == BAND_HALF_HR) ? prod_reg + NUM_W'(DUR_12HR)
                                                  : prod_reg;
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            out_valid  <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            out_valid  <= s3_vld_reg;
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg    <= cls_next;
            s2_reg    <= s1_reg;
            q0_reg    <= q0_next;
            s3_reg    <= s2_reg;
            q0_s3_reg <= q0_reg;
            prod_reg  <= step_prod[NUM_W-1:0];
            if (s3_reg.op == OP_DECODE)
            begin
                code_out    <= 8'd0;
                seconds_out <= secs_next;
                saturated   <= 1'b0;
            end
            else
            begin
                code_out    <= code_next;
                seconds_out <= '0;
                saturated   <= s3_reg.sat;
            end
        end
    end

endmodule

`default_nettype wire

// ===== verif/vprc_conversion_checker.sv =====
// Checker for the validity period codec: predicts each transfer and compares results.
`timescale 1ns / 1ps

module vprc_conversion_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic        operation,
    input  wire logic [31:0] duration_seconds,
    input  wire logic [7:0]  period_code,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [7:0]  code_out,
    input  wire logic [25:0] seconds_out,
    input  wire logic        saturated,
    output int               fail_count,
    output int               pending_count,
    output int               compared_count
);
    import vprc_pkg::*;

    typedef struct packed {
        logic [7:0]  code;
        logic [25:0] seconds;
        logic        sat;
    } conversion_t;

    conversion_t awaited_conversions[$];
    int          fails;
    int          reported;
    int          compared;

    // Expected result for one input transfer
    function automatic conversion_t predict_conversion(input logic        op,
                                                       input logic [31:0] secs,
                                                       input logic [7:0]  code);
        conversion_t r;
        logic [31:0] v;
        logic [31:0] q;
        logic [31:0] c32;
        r   = '0;
        v   = secs;
        c32 = {24'd0, code};
        if (op == OP_ENCODE)
        begin
            if (v <= DUR_12HR)
            begin
                if (v < DUR_5MIN)
                    v = DUR_5MIN;
                q = v / DUR_5MIN - 32'd1;
            end
            else if (v <= DUR_1DAY)
            begin
                q = (v - DUR_12HR) / DUR_30MIN + 32'(CODE_HALF_DAY);
            end
            else if (v <= DUR_30DAY)
            begin
                if (v < DUR_2DAY)
                    v = DUR_2DAY;
                q = v / DUR_1DAY + 32'(CODE_DAY_BASE);
            end
            else if (v <= DUR_63WEEK)
            begin
                if (v < DUR_5WEEK)
                    v = DUR_5WEEK;
                q = v / DUR_1WEEK + 32'(CODE_WEEK_BASE);
            end
            else
            begin
                q     = 32'(CODE_MAX);
                r.sat = 1'b1;
            end
            r.code = q[7:0];
        end
        else
        begin
            if (code <= CODE_HALF_DAY)
                q = (c32 + 32'd1) * DUR_5MIN;
            else if (code <= CODE_DAY)
                q = (c32 - 32'(CODE_HALF_DAY)) * DUR_30MIN + DUR_12HR;
            else if (code <= CODE_MONTH)
                q = (c32 - 32'(CODE_DAY_BASE)) * DUR_1DAY;
            else
                q = (c32 - 32'(CODE_WEEK_BASE)) * DUR_1WEEK;
            r.seconds = q[25:0];
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        conversion_t want;
        conversion_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                awaited_conversions.push_back(
                    predict_conversion(operation, duration_seconds, period_code));
            if (out_valid && out_ready)
            begin
                got = '{code_out, seconds_out, saturated};
                if (awaited_conversions.size() == 0)
                begin
                    fails++;
                    if (reported < 10)
                        $display("unexpected result: code=%0d seconds=%0d sat=%0b",
                                 got.code, got.seconds, got.sat);
                    reported++;
                end
                else
                begin
                    want = awaited_conversions.pop_front();
                    compared++;
                    if (got.code !== want.code || got.seconds !== want.seconds
                        || got.sat !== want.sat)
                    begin
                        fails++;
                        if (reported < 10)
                        begin
                            $write("mismatch: expected code=%0d seconds=%0d sat=%0b,",
                                   want.code, want.seconds, want.sat);
                            $display(" got code=%0d seconds=%0d sat=%0b",
                                     got.code, got.seconds, got.sat);
                        end
                        reported++;
                    end
                end
            end
        end
        fail_count     <= fails;
        pending_count  <= awaited_conversions.size();
        compared_count <= compared;
    end

endmodule

// ===== verif/validity_period_relative_codec_test.sv =====
// Top of the validity period codec testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module validity_period_relative_codec_test;

    import vprc_pkg::*;

    // Run shape
    localparam int RANDOM_ITEMS = 1925;
    localparam int QUIET_FROM   = 1000;   // no idling on either side in this window
    localparam int QUIET_TO     = 1400;
    localparam int HOLD_AT      = 500;    // receiver hold-off starts after this many transfers
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 16;     // pipeline is 4 deep; plenty of margin
    // The limit sits well above the slowest correct run, which grows with the items,
    // the sender gaps, the receiver stalls and the hold-off.
    localparam int CYCLE_LIMIT  = 200000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        operation;
    logic [31:0] duration_seconds;
    logic [7:0]  period_code;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  code_out;
    logic [25:0] seconds_out;
    logic        saturated;

    int fail_count;
    int pending_count;
    int compared_count;

    int items_sent;
    int encodes_sent;
    int decodes_sent;
    int cycle_count;
    int hold_left;
    bit hold_started;

    localparam logic [31:0] BAND_EDGES [7] = '{DUR_5MIN, DUR_12HR, DUR_1DAY, DUR_2DAY,
                                               DUR_30DAY, DUR_5WEEK, DUR_63WEEK};

    validity_period_relative_codec dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .duration_seconds (duration_seconds),
        .period_code      (period_code),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .code_out         (code_out),
        .seconds_out      (seconds_out),
        .saturated        (saturated)
    );

    vprc_conversion_checker checker_inst (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .duration_seconds (duration_seconds),
        .period_code      (period_code),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .code_out         (code_out),
        .seconds_out      (seconds_out),
        .saturated        (saturated),
        .fail_count       (fail_count),
        .pending_count    (pending_count),
        .compared_count   (compared_count)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic bit quiet_window();
        return items_sent >= QUIET_FROM && items_sent < QUIET_TO;
    endfunction

    // Encode durations spread over every band, the edges, and the saturated range
    function automatic logic [31:0] pick_duration();
        logic [31:0] d;
        case ($urandom_range(0, 6))
            0:       d = $urandom;
            1:       d = $urandom_range(0, DUR_12HR);
            2:       d = $urandom_range(DUR_12HR + 1, DUR_1DAY);
            3:       d = $urandom_range(DUR_1DAY + 1, DUR_30DAY);
            4:       d = $urandom_range(DUR_30DAY + 1, DUR_63WEEK);
            5:       d = BAND_EDGES[$urandom_range(0, 6)] + $urandom_range(0, 4) - 32'd2;
            default: d = $urandom_range(DUR_63WEEK + 1, 32'hFFFF_FFFF);
        endcase
        return d;
    endfunction

    // Entered and left at a falling edge. Outside the quiet window, random idle cycles
    // go in front of the item; then valid is held until the transfer completes.
    task automatic offer_item(input logic op, input logic [31:0] secs, input logic [7:0] code);
        if (!quiet_window())
        begin
            while ($urandom_range(0, 99) < 21)
            begin
                in_valid         <= 1'b0;
                operation        <= 1'($urandom);
                duration_seconds <= $urandom;
                period_code      <= 8'($urandom);
                @(negedge clk);
            end
        end
        in_valid         <= 1'b1;
        operation        <= op;
        duration_seconds <= secs;
        period_code      <= code;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        if (op == OP_ENCODE)
            encodes_sent++;
        else
            decodes_sent++;
        @(negedge clk);
    endtask

    // Cycle limit: a hang anywhere ends the run as a failure
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still pending",
                 cycle_count, pending_count);
        $display("validity_period_relative_codec_test: errors");
        $finish;
    end

    // Receiver: random back-pressure, one long hold-off so the pipeline fills and
    // stalls the input, and an idle-free window in the middle of the run.
    initial
    begin
        out_ready    = 1'b0;
        hold_left    = 0;
        hold_started = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_started && items_sent >= HOLD_AT)
            begin
                hold_started = 1'b1;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (quiet_window())
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= 21);
            end
        end
    end

    // Sender and verdict
    initial
    begin
        logic op;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        operation        = OP_ENCODE;
        duration_seconds = '0;
        period_code      = '0;
        items_sent       = 0;
        encodes_sent     = 0;
        decodes_sent     = 0;
        cycle_count      = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: zero and under five minutes, each band edge with a neighbor, the
        // one-to-two-day and 30-day-to-5-week gaps, saturation, all-ones input and the
        // decode band edges. The ignored field carries random, all-ones or zero content.
        offer_item(OP_ENCODE, 32'd0,           8'hFF);
        offer_item(OP_ENCODE, DUR_5MIN - 1,    8'($urandom));
        offer_item(OP_ENCODE, DUR_5MIN,        8'($urandom));
        offer_item(OP_ENCODE, DUR_12HR - 1,    8'($urandom));
        offer_item(OP_ENCODE, DUR_12HR,        8'($urandom));
        offer_item(OP_ENCODE, DUR_12HR + 1,    8'($urandom));
        offer_item(OP_ENCODE, DUR_1DAY,        8'($urandom));
        offer_item(OP_ENCODE, DUR_1DAY + 1,    8'($urandom));
        offer_item(OP_ENCODE, DUR_2DAY - 1,    8'($urandom));
        offer_item(OP_ENCODE, DUR_2DAY,        8'($urandom));
        offer_item(OP_ENCODE, DUR_30DAY,       8'($urandom));
        offer_item(OP_ENCODE, DUR_30DAY + 1,   8'($urandom));
        offer_item(OP_ENCODE, DUR_5WEEK - 1,   8'($urandom));
        offer_item(OP_ENCODE, DUR_5WEEK,       8'($urandom));
        offer_item(OP_ENCODE, DUR_63WEEK,      8'($urandom));
        offer_item(OP_ENCODE, DUR_63WEEK + 1,  8'($urandom));
        offer_item(OP_ENCODE, 32'hFFFF_FFFF,   8'hFF);
        offer_item(OP_DECODE, 32'hFFFF_FFFF,   8'd0);
        offer_item(OP_DECODE, $urandom,        CODE_HALF_DAY);
        offer_item(OP_DECODE, $urandom,        CODE_HALF_DAY + 8'd1);
        offer_item(OP_DECODE, $urandom,        CODE_DAY);
        offer_item(OP_DECODE, $urandom,        CODE_DAY + 8'd1);
        offer_item(OP_DECODE, $urandom,        CODE_MONTH);
        offer_item(OP_DECODE, $urandom,        CODE_MONTH + 8'd1);
        offer_item(OP_DECODE, 32'd0,           CODE_MAX);

        // Random: both directions, random content in the ignored field
        repeat (RANDOM_ITEMS)
        begin
            op = 1'($urandom_range(0, 1));
            if (op == OP_ENCODE)
                offer_item(op, pick_duration(), 8'($urandom));
            else
                offer_item(op, $urandom, 8'($urandom_range(0, 255)));
        end
        in_valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d encode and %0d decode transfers, %0d results compared",
                 encodes_sent, decodes_sent, compared_count);
        $display("band edges, saturation, an idle-free window and a %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending_count == 0)
            $display("validity_period_relative_codec_test: clean");
        else
            $display("validity_period_relative_codec_test: errors");
        $finish;
    end

endmodule
